// ===== rtl/first_fit_unit_allocator_core_assert.svh =====
// Assertion macros shared by the checker of the allocator core.
// Depends on a clock named i_clk and an active low reset named i_rst_n in scope.
`ifndef FIRST_FIT_UNIT_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_UNIT_ALLOCATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FFUA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("allocator assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FFUA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("allocator assertion failed");

`endif

// ===== rtl/ffua_pkg.sv =====
// Package of the first-fit unit allocator: payload types, token types and constants.
// Used by every module of the block; depends on nothing.
package ffua_pkg;

    localparam int MAP_UNITS_DEF = 128;
    localparam int UNITS_W       = 8;
    localparam int START_W       = 7;
    localparam int LEN_W         = 8;
    localparam int POS_W         = 9;

    localparam logic [UNITS_W-1:0] UNITS_RESET = 8'd128;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [START_W-1:0] start_unit;
        logic [LEN_W-1:0]   length;
    } t_in;

    typedef struct packed {
        logic               success;
        logic [START_W-1:0] found_start;
    } t_out;

    typedef struct packed {
        logic             valid;
        logic             found;
        logic [POS_W-1:0] run;
        logic [POS_W-1:0] start;
        logic [LEN_W-1:0] len;
    } t_token;

    typedef struct packed {
        logic             valid;
        logic             set_bit;
        logic [POS_W-1:0] lo;
        logic [POS_W-1:0] hi;
    } t_upd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

// ===== rtl/ffua_cell.sv =====
// One map cell of the allocator: holds the used bit of one unit and passes the scan token on.
// Depends on ffua_pkg.
module ffua_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [ffua_pkg::UNITS_W-1:0]  i_units,
    input  ffua_pkg::t_token              i_tok,
    input  ffua_pkg::t_upd                i_upd,
    output ffua_pkg::t_token              o_tok
);

    localparam logic IN_RANGE = (CELL_IDX < (1 << ffua_pkg::UNITS_W));
    localparam logic [ffua_pkg::POS_W-1:0] K =
        IN_RANGE ? ffua_pkg::POS_W'(CELL_IDX) : '0;

    logic                         r_used;
    logic                         n_used;
    ffua_pkg::t_token             r_tok;
    ffua_pkg::t_token             n_tok;
    logic                         w_managed;
    logic [ffua_pkg::POS_W-1:0]   w_run;
    logic [ffua_pkg::POS_W-1:0]   w_len;
    logic                         w_hit;

    always_comb begin
        w_managed = IN_RANGE && (K < ffua_pkg::POS_W'(i_units));
        w_len     = ffua_pkg::POS_W'(i_tok.len);
        w_run     = r_used ? '0 : i_tok.run + 1'b1;
        w_hit     = !r_used && ((i_tok.len == '0) || (w_run == w_len));

        n_tok = i_tok;
        if (i_tok.valid && w_managed && !i_tok.found) begin
            n_tok.run = w_run;
            if (w_hit) begin
                n_tok.found = 1'b1;
                n_tok.start = (i_tok.len == '0) ? K : K + 1'b1 - w_len;
            end
        end

        n_used = r_used;
        if (i_upd.valid && w_managed && (K >= i_upd.lo) && (K < i_upd.hi)) begin
            n_used = i_upd.set_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
            r_tok  <= '0;
        end else begin
            r_used <= n_used;
            r_tok  <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== rtl/first_fit_unit_allocator_core.sv =====
// Top level of the first-fit unit allocator: controller, configuration register and cell chain.
// Depends on ffua_pkg and ffua_cell.
//
//  channel  direction  handshake            payload
//  in       input      i_in_valid/o_in_stall   i_in_data (t_in)
//  out      output     o_out_valid/i_out_stall o_out_data (t_out)
//  cfg      input      i_cfg_valid/o_cfg_ready i_cfg_data (units in use)
//
// An allocate transaction sends a scan token down the cell chain, one cell per cycle, and its
// result is registered after the token leaves the last cell; a free skips the scan.
// One transaction is handled at a time; a result waits in the output register under stall.
// Reset clears the whole map to free and sets units in use to 128.
module first_fit_unit_allocator_core #(
    parameter int MAP_UNITS = ffua_pkg::MAP_UNITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  ffua_pkg::t_in                 i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output ffua_pkg::t_out                o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ffua_pkg::UNITS_W-1:0]  i_cfg_data
);

    ffua_pkg::t_state                      r_state;
    ffua_pkg::t_state                      n_state;
    logic [ffua_pkg::UNITS_W-1:0]          r_units;
    logic                                  r_cmd;
    logic [ffua_pkg::START_W-1:0]          r_start;
    logic [ffua_pkg::LEN_W-1:0]            r_len;
    logic                                  r_found;
    logic [ffua_pkg::POS_W-1:0]            r_fstart;
    logic                                  r_out_valid;
    ffua_pkg::t_out                        r_out;
    ffua_pkg::t_out                        w_result;
    ffua_pkg::t_upd                        w_upd;
    ffua_pkg::t_token                      w_tok [MAP_UNITS+1];
    logic                                  w_accept;
    logic                                  w_push;
    logic [ffua_pkg::POS_W-1:0]            w_lo;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ffua_pkg::ST_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_push      = (r_state == ffua_pkg::ST_DONE) && (!r_out_valid || !i_out_stall);

    assign w_tok[0] = '{
        valid: w_accept && (i_in_data.cmd == ffua_pkg::CMD_ALLOC),
        found: 1'b0,
        run:   '0,
        start: '0,
        len:   i_in_data.length
    };

    for (genvar g = 0; g < MAP_UNITS; g++) begin : g_cell
        ffua_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_units (r_units),
            .i_tok   (w_tok[g]),
            .i_upd   (w_upd),
            .o_tok   (w_tok[g+1])
        );
    end

    always_comb begin
        w_lo          = (r_cmd == ffua_pkg::CMD_FREE) ? ffua_pkg::POS_W'(r_start) : r_fstart;
        w_upd.valid   = w_push && ((r_cmd == ffua_pkg::CMD_FREE) || r_found);
        w_upd.set_bit = (r_cmd == ffua_pkg::CMD_ALLOC);
        w_upd.lo      = w_lo;
        w_upd.hi      = w_lo + ffua_pkg::POS_W'(r_len);

        if (r_cmd == ffua_pkg::CMD_FREE) begin
            w_result.success     = 1'b1;
            w_result.found_start = '0;
        end else begin
            w_result.success     = r_found;
            w_result.found_start = r_found ? r_fstart[ffua_pkg::START_W-1:0] : '0;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ffua_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = (i_in_data.cmd == ffua_pkg::CMD_FREE) ? ffua_pkg::ST_DONE
                                                                     : ffua_pkg::ST_SCAN;
                end
            end
            ffua_pkg::ST_SCAN: begin
                if (w_tok[MAP_UNITS].valid) begin
                    n_state = ffua_pkg::ST_DONE;
                end
            end
            ffua_pkg::ST_DONE: begin
                if (w_push) begin
                    n_state = ffua_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ffua_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ffua_pkg::ST_IDLE;
            r_units     <= ffua_pkg::UNITS_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_units <= i_cfg_data;
            end
            if (w_push) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= i_in_data.cmd;
            r_start <= i_in_data.start_unit;
            r_len   <= i_in_data.length;
            r_found <= 1'b0;
        end
        if (r_state == ffua_pkg::ST_SCAN && w_tok[MAP_UNITS].valid) begin
            r_found  <= w_tok[MAP_UNITS].found;
            r_fstart <= w_tok[MAP_UNITS].start;
        end
        if (w_push) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/ffua_chk.sv =====
// Port-level checker of the allocator core and the bind that attaches it.
// Depends on ffua_pkg and first_fit_unit_allocator_core_assert.svh.
`include "first_fit_unit_allocator_core_assert.svh"

module ffua_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input ffua_pkg::t_in                 i_in_data,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input ffua_pkg::t_out                o_out_data
);

    // A stalled result stays offered and unchanged.
    `FFUA_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid)
    `FFUA_ASSERT_NEXT(a_out_stable, o_out_valid && i_out_stall, $stable(o_out_data))

    // After a transaction is taken, the input side stalls while it is worked on.
    `FFUA_ASSERT_NEXT(a_one_at_a_time, i_in_valid && !o_in_stall, o_in_stall)

    // An allocation keeps the input side stalled during its scan.
    `FFUA_ASSERT_NEXT(a_alloc_scan,
        i_in_valid && !o_in_stall && (i_in_data.cmd == ffua_pkg::CMD_ALLOC),
        o_in_stall ##1 o_in_stall)

endmodule

bind first_fit_unit_allocator_core ffua_chk u_ffua_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ===== tb/first_fit_unit_allocator_core_test.sv =====
// Self-checking testbench of first_fit_unit_allocator_core: a directed script, then random
// allocate and free traffic under several unit counts, checked against a bitmap predictor.
// Depends on ffua_pkg and first_fit_unit_allocator_core.
module first_fit_unit_allocator_core_test;

    localparam int MAP_UNITS    = ffua_pkg::MAP_UNITS_DEF;
    localparam int CLK_PERIOD   = 10;
    localparam int LIMIT_CYCLES = 1_500_000;
    localparam int SEGMENTS     = 8;

    typedef enum bit {
        ROW_REQ,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind                    kind;
        logic [ffua_pkg::UNITS_W-1:0] cfg_value;
        ffua_pkg::t_in                req;
        bit                           typed;
        ffua_pkg::t_out               known;
    } t_script_row;

    typedef struct {
        logic [ffua_pkg::START_W-1:0] first;
        logic [ffua_pkg::LEN_W-1:0]   count;
    } t_held_run;

    localparam t_script_row SCRIPT [0:30] = '{
        '{ROW_REQ, 8'd0,   '{ffua_pkg::CMD_ALLOC, 7'd0,   8'd0},   1'b1, '{1'b1, 7'd0}},
        '{ROW_REQ, 8'd0,   '{ffua_pkg::CMD_ALLOC, 7'd0,   8'd1},   1'b1, '{1'b1, 7'd0}},
        '{ROW_REQ, 8'd0,   '{ffua_pkg::CMD_ALLOC, 7'd0,   8'd128}, 1'b1, '{1'b0, 7'd0}},
        '{ROW_REQ, 8'd0,   '{ffua_pkg::CMD_ALLOC, 7'd0,   8'd255}, 1'b1, '{1'b0, 7'd0}},
        '{ROW_REQ, 8'd0,   '{ffua_pkg::CMD_FREE,  7'd0,   8'd1},   1'b1, '{1'b1, 7'd0}},
        '{ROW_REQ, 8'd0,   '{ffua_pkg::CMD_ALLOC, 7'd0,   8'd128}, 1'b1, '{1'b1, 7'd0}},
        '{ROW_REQ, 8'd0,   '{ffua_pkg::CMD_ALLOC, 7'd0,   8'd0},   1'b1, '{1'b0, 7'd0}},
        '{ROW_REQ, 8'd0,   '{ffua_pkg::CMD_FREE,  7'd127, 8'd255}, 1'b1, '{1'b1, 7'd0}},
        '{ROW_REQ, 8'd0,   '{ffua_pkg::CMD_ALLOC, 7'd0,   8'd0},   1'b1, '{1'b1, 7'd127}},
        '{ROW_REQ, 8'd0,   '{ffua_pkg::CMD_ALLOC, 7'd0,   8'd1},   1'b1, '{1'b1, 7'd127}},
        '{ROW_REQ, 8'd0,   '{ffua_pkg::CMD_FREE,  7'd0,   8'd0},   1'b1, '{1'b1, 7'd0}},
        '{ROW_REQ, 8'd0,   '{ffua_pkg::CMD_FREE,  7'd64,  8'd128}, 1'b1, '{1'b1, 7'd0}},
        '{ROW_REQ, 8'd0,   '{ffua_pkg::CMD_ALLOC, 7'd127, 8'd64},  1'b1, '{1'b1, 7'd64}},
        '{ROW_REQ, 8'd0,   '{ffua_pkg::CMD_FREE,  7'd0,   8'd128}, 1'b1, '{1'b1, 7'd0}},
        '{ROW_CFG, 8'd0,   '{ffua_pkg::CMD_ALLOC, 7'd0,   8'd0},   1'b0, '{1'b0, 7'd0}},
        '{ROW_REQ, 8'd0,   '{ffua_pkg::CMD_ALLOC, 7'd0,   8'd0},   1'b1, '{1'b0, 7'd0}},
        '{ROW_REQ, 8'd0,   '{ffua_pkg::CMD_FREE,  7'd5,   8'd3},   1'b1, '{1'b1, 7'd0}},
        '{ROW_CFG, 8'd1,   '{ffua_pkg::CMD_ALLOC, 7'd0,   8'd0},   1'b0, '{1'b0, 7'd0}},
        '{ROW_REQ, 8'd0,   '{ffua_pkg::CMD_ALLOC, 7'd0,   8'd2},   1'b1, '{1'b0, 7'd0}},
        '{ROW_REQ, 8'd0,   '{ffua_pkg::CMD_ALLOC, 7'd0,   8'd1},   1'b1, '{1'b1, 7'd0}},
        '{ROW_REQ, 8'd0,   '{ffua_pkg::CMD_ALLOC, 7'd0,   8'd0},   1'b1, '{1'b0, 7'd0}},
        '{ROW_REQ, 8'd0,   '{ffua_pkg::CMD_FREE,  7'd0,   8'd1},   1'b1, '{1'b1, 7'd0}},
        '{ROW_CFG, 8'd255, '{ffua_pkg::CMD_ALLOC, 7'd0,   8'd0},   1'b0, '{1'b0, 7'd0}},
        '{ROW_REQ, 8'd0,   '{ffua_pkg::CMD_ALLOC, 7'd0,   8'd128}, 1'b1, '{1'b1, 7'd0}},
        '{ROW_REQ, 8'd0,   '{ffua_pkg::CMD_FREE,  7'd100, 8'd200}, 1'b1, '{1'b1, 7'd0}},
        '{ROW_REQ, 8'd0,   '{ffua_pkg::CMD_ALLOC, 7'd0,   8'd30},  1'b1, '{1'b0, 7'd0}},
        '{ROW_REQ, 8'd0,   '{ffua_pkg::CMD_ALLOC, 7'd85,  8'd28},  1'b1, '{1'b1, 7'd100}},
        '{ROW_REQ, 8'd0,   '{ffua_pkg::CMD_FREE,  7'd10,  8'd5},   1'b1, '{1'b1, 7'd0}},
        '{ROW_REQ, 8'd0,   '{ffua_pkg::CMD_ALLOC, 7'd0,   8'd3},   1'b0, '{1'b0, 7'd0}},
        '{ROW_REQ, 8'd0,   '{ffua_pkg::CMD_ALLOC, 7'd0,   8'd4},   1'b0, '{1'b0, 7'd0}},
        '{ROW_REQ, 8'd0,   '{ffua_pkg::CMD_FREE,  7'd0,   8'd128}, 1'b1, '{1'b1, 7'd0}}
    };

    // Segment five draws its unit count at random.
    localparam logic [ffua_pkg::UNITS_W-1:0] SEG_UNITS [SEGMENTS] =
        '{8'd128, 8'd255, 8'd2, 8'd0, 8'd1, 8'd0, 8'd127, 8'd128};
    localparam int SEG_ITEMS [SEGMENTS] = '{400, 300, 60, 30, 30, 350, 300, 230};

    logic                         i_clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    ffua_pkg::t_in                in_data = '0;
    logic                         out_stall = 1'b0;
    logic                         cfg_valid = 1'b0;
    logic [ffua_pkg::UNITS_W-1:0] cfg_data = '0;
    logic                         o_in_stall;
    logic                         o_out_valid;
    ffua_pkg::t_out               o_out_data;
    logic                         o_cfg_ready;

    bit [MAP_UNITS-1:0]           used_units = '0;
    logic [ffua_pkg::UNITS_W-1:0] units_setting = ffua_pkg::UNITS_RESET;
    ffua_pkg::t_out               grant_q[$];
    t_held_run                    held_runs[$];

    int send_idle_pct = 14;
    int recv_stall_pct = 55;
    int mismatches = 0;
    int granted_cnt = 0;
    int refused_cnt = 0;
    int freed_cnt = 0;
    int setting_cnt = 0;

    first_fit_unit_allocator_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    function automatic ffua_pkg::t_out predict_grant(input ffua_pkg::t_in req);
        ffua_pkg::t_out res;
        int   limit;
        int   first;
        int   count;
        int   i;
        int   k;
        bit   fits;
        res   = '0;
        limit = (units_setting < MAP_UNITS) ? int'(units_setting) : MAP_UNITS;
        first = int'(req.start_unit);
        count = int'(req.length);
        if (req.cmd == ffua_pkg::CMD_FREE) begin
            for (k = first; k < first + count && k < limit; k++) begin
                used_units[k] = 1'b0;
            end
            res.success = 1'b1;
            return res;
        end
        for (i = 0; i < limit; i++) begin
            if (!used_units[i]) begin
                if (i + count > limit) begin
                    break;
                end
                fits = 1'b1;
                for (k = i; k < i + count; k++) begin
                    if (used_units[k]) begin
                        fits = 1'b0;
                    end
                end
                if (fits) begin
                    for (k = i; k < i + count; k++) begin
                        used_units[k] = 1'b1;
                    end
                    res.success     = 1'b1;
                    res.found_start = ffua_pkg::START_W'(i);
                    return res;
                end
            end
        end
        return res;
    endfunction

    // Most frees release a run that was granted earlier; the rest hit arbitrary ranges.
    function automatic ffua_pkg::t_in make_request();
        ffua_pkg::t_in req;
        int  pick;
        int  sel;
        req.start_unit = ffua_pkg::START_W'($urandom_range(MAP_UNITS - 1));
        pick = $urandom_range(99);
        if (pick < 52) begin
            req.cmd = ffua_pkg::CMD_ALLOC;
            sel = $urandom_range(99);
            if (sel < 75) begin
                req.length = ffua_pkg::LEN_W'($urandom_range(16));
            end else if (sel < 95) begin
                req.length = ffua_pkg::LEN_W'($urandom_range(MAP_UNITS));
            end else begin
                req.length = ffua_pkg::LEN_W'($urandom_range(255, MAP_UNITS + 1));
            end
        end else if (pick < 88 && held_runs.size() != 0) begin
            sel = $urandom_range(held_runs.size() - 1);
            req.cmd        = ffua_pkg::CMD_FREE;
            req.start_unit = held_runs[sel].first;
            req.length     = held_runs[sel].count;
            held_runs.delete(sel);
        end else begin
            req.cmd    = ffua_pkg::CMD_FREE;
            req.length = ($urandom_range(3) == 0) ? ffua_pkg::LEN_W'($urandom_range(255))
                                                  : ffua_pkg::LEN_W'($urandom_range(20));
        end
        return req;
    endfunction

    task automatic send_request(input ffua_pkg::t_in req, input bit typed,
                                input ffua_pkg::t_out known);
        ffua_pkg::t_out predicted;
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge i_clk); while (o_in_stall);
        predicted = predict_grant(req);
        grant_q.push_back(typed ? known : predicted);
        if (req.cmd == ffua_pkg::CMD_FREE) begin
            freed_cnt++;
        end else if (predicted.success) begin
            granted_cnt++;
            if (req.length != 0) begin
                held_runs.push_back('{predicted.found_start, req.length});
            end
        end else begin
            refused_cnt++;
        end
    endtask

    task automatic write_units(input logic [ffua_pkg::UNITS_W-1:0] value);
        in_valid <= 1'b0;
        while (grant_q.size() != 0) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        units_setting = value;
        setting_cnt++;
    endtask

    function automatic void note_mismatch(input string field, input logic [7:0] want,
                                          input logic [7:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch in %s: expected %0h, got %0h", field, want, got);
        end
    endfunction

    always @(posedge i_clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

    always @(posedge i_clk) begin
        ffua_pkg::t_out want;
        if (rst_n && o_out_valid && !out_stall) begin
            if (grant_q.size() == 0) begin
                note_mismatch("unrequested result", 8'h00, o_out_data);
            end else begin
                want = grant_q.pop_front();
                if (o_out_data.success !== want.success) begin
                    note_mismatch("success", 8'(want.success), 8'(o_out_data.success));
                end
                if (o_out_data.found_start !== want.found_start) begin
                    note_mismatch("found_start", 8'(want.found_start),
                                  8'(o_out_data.found_start));
                end
            end
        end
    end

    initial begin
        int seg;
        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;
        foreach (SCRIPT[r]) begin
            if (SCRIPT[r].kind == ROW_CFG) begin
                write_units(SCRIPT[r].cfg_value);
            end else begin
                send_request(SCRIPT[r].req, SCRIPT[r].typed, SCRIPT[r].known);
            end
        end
        for (seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == 3) begin
                send_idle_pct  = 55;
                recv_stall_pct = 14;
            end
            if (seg == 6) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            write_units(seg == 5 ? ffua_pkg::UNITS_W'($urandom_range(126, 3))
                                 : SEG_UNITS[seg]);
            repeat (SEG_ITEMS[seg]) send_request(make_request(), 1'b0, '0);
        end
        in_valid <= 1'b0;
        while (grant_q.size() != 0) @(posedge i_clk);
        repeat (MAP_UNITS + 8) @(posedge i_clk);
        $display("Covered %0d allocations granted, %0d refused and %0d frees over %0d unit counts.",
                 granted_cnt, refused_cnt, freed_cnt, setting_cnt);
        $display("Mismatches found: %0d.", mismatches);
        if (mismatches == 0 && grant_q.size() == 0) begin
            $display("first_fit_unit_allocator_core test passed");
        end else begin
            $display("first_fit_unit_allocator_core test failed");
        end
        $finish;
    end

    initial begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("Timed out with %0d results still outstanding.", grant_q.size());
        $display("first_fit_unit_allocator_core test failed");
        $finish;
    end

endmodule
